/* sv/atl_pkg.sv */
// atl_pkg: shared widths, defaults, tag type and the arctangent table function
// for the accelerometer tilt angle pipeline. No dependencies.
package atl_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF  = 16;

    // radicand is always 62 bits wide: 2*SAMPLE_WIDTH + 2*(31 - SAMPLE_WIDTH)
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int CW         = 34;     // cordic x/y word
    localparam int ZW         = 49;     // angle accumulator, 2^-40 degree units
    localparam int TABLE_BITS = 40;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;

    // special-case tag carried alongside the data
    typedef struct packed {
        logic spec;     // both other axes zero
        logic neg;      // own axis negative
        logic zero;     // own axis zero
    } t_tag;

    // shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned atl_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees, units of 2^-40 degree
    function automatic logic [ZW-1:0] atl_angle(input int idx);
        longint unsigned rad;
        longint unsigned term;
        int unsigned     e;
        rad = 64'd0;
        if (idx == 0) begin
            rad = PI_Q60;
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = idx * (2 * k + 1);
                if (e <= 62) begin
                    term = atl_udiv(64'd1 << (62 - e), longint'(2 * k + 1));
                    if ((k & 1) == 1) rad = rad - term;
                    else              rad = rad + term;
                end
            end
        end
        return ZW'(atl_udiv((rad >> 22) * 64'd57295, 64'd1000));
    endfunction

endpackage

/* sv/atl_ifs.sv */
// atl_ifs: valid/ready channel interfaces for samples and angles
// depends on nothing
interface atl_smp_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic signed [W-1:0] accel_z;
    modport src (output valid, accel_x, accel_y, accel_z, input ready);
    modport snk (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atl_ang_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] angle_x;
    logic signed [W-1:0] angle_y;
    logic signed [W-1:0] angle_z;
    modport src (output valid, angle_x, angle_y, angle_z, input ready);
    modport snk (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

/* sv/atl_isqrt.sv */
// atl_isqrt: pipelined floor square root, one root bit per stage
// depends on atl_pkg
module atl_isqrt import atl_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  w_rad  [0:ROOT_W];
    logic [REM_W-1:0]  w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];
    logic [SIDE_W-1:0] w_side [0:ROOT_W];

    logic [RAD_W-1:0]  r_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [SIDE_W-1:0] r_side [0:ROOT_W-1];

    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic             ge;

        assign cur   = {w_rem[k], w_rad[k][RAD_W-1 -: 2]};
        assign trial = {2'b00, w_root[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {w_rad[k][RAD_W-3:0], 2'b00};
                r_rem[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                r_root[k] <= {w_root[k][ROOT_W-2:0], ge};
                r_side[k] <= w_side[k];
            end
        end

        assign w_rad[k+1]  = r_rad[k];
        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_root = w_root[ROOT_W];
    assign o_side = w_side[ROOT_W];
endmodule

/* sv/atl_cordic.sv */
// atl_cordic: vectoring cordic, one rotation per register stage
// depends on atl_pkg
module atl_cordic import atl_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  t_tag                 i_tag,
    output logic signed [ZW-1:0] o_z,
    output t_tag                 o_tag
);
    logic signed [CW-1:0] w_x [0:CORDIC_STEPS];
    logic signed [CW-1:0] w_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] w_z [0:CORDIC_STEPS];
    t_tag                 w_t [0:CORDIC_STEPS];

    logic signed [CW-1:0] r_x [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] r_y [0:CORDIC_STEPS-1];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS-1];
    t_tag                 r_t [0:CORDIC_STEPS-1];

    assign w_x[0] = i_x;
    assign w_y[0] = i_y;
    assign w_z[0] = '0;
    assign w_t[0] = i_tag;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ANG = atl_angle(i);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = w_y[i] >>> i;
        assign dy = w_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[i][CW-1]) begin
                    r_x[i] <= w_x[i] + dx;
                    r_y[i] <= w_y[i] - dy;
                    r_z[i] <= w_z[i] + ANG;
                end else begin
                    r_x[i] <= w_x[i] - dx;
                    r_y[i] <= w_y[i] + dy;
                    r_z[i] <= w_z[i] - ANG;
                end
                r_t[i] <= w_t[i];
            end
        end

        assign w_x[i+1] = r_x[i];
        assign w_y[i+1] = r_y[i];
        assign w_z[i+1] = r_z[i];
        assign w_t[i+1] = r_t[i];
    end

    assign o_z   = w_z[CORDIC_STEPS];
    assign o_tag = w_t[CORDIC_STEPS];
endmodule

/* sv/atl_lane.sv */
// atl_lane: one tilt angle: squares, radicand, square root, cordic, rounding
// depends on atl_pkg, atl_isqrt, atl_cordic
module atl_lane import atl_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_own,
    input  logic signed [SAMPLE_WIDTH-1:0] i_oth_b,
    input  logic signed [SAMPLE_WIDTH-1:0] i_oth_c,
    output logic signed [FRACTION_BITS+7:0] o_angle
);
    localparam int SW     = SAMPLE_WIDTH;
    localparam int OW     = FRACTION_BITS + 8;
    localparam int GUARD  = 31 - SW;
    localparam int DROP   = TABLE_BITS - FRACTION_BITS;
    localparam int SIDE_W = CW + $bits(t_tag);
    localparam logic [ZW-1:0] FULL_Z = ZW'(90) << FRACTION_BITS;
    localparam logic [ZW-1:0] HALF_Z = ZW'(1) << (DROP - 1);

    // stage 1: squares
    logic signed [2*SW-1:0] r_sq_b, r_sq_c;
    logic signed [CW-1:0]   r_y1, r_y2;
    t_tag                   r_tag1, r_tag2, n_tag;

    // stage 2: radicand
    logic [RAD_W-1:0] r_rad;
    logic [2*SW-1:0]  w_sum;

    assign n_tag.spec = (i_oth_b == '0) && (i_oth_c == '0);
    assign n_tag.neg  = i_own[SW-1];
    assign n_tag.zero = (i_own == '0);
    assign w_sum      = r_sq_b + r_sq_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_b <= i_oth_b * i_oth_b;
            r_sq_c <= i_oth_c * i_oth_c;
            r_y1   <= CW'(i_own) <<< GUARD;
            r_tag1 <= n_tag;
            r_rad  <= {w_sum, {(2*GUARD){1'b0}}};
            r_y2   <= r_y1;
            r_tag2 <= r_tag1;
        end
    end

    logic [ROOT_W-1:0] w_root;
    logic [SIDE_W-1:0] w_side;
    t_tag              w_tag_s, w_tag_c;
    logic signed [ZW-1:0] w_z;

    atl_isqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rad (r_rad),
        .i_side({r_tag2, r_y2}),
        .o_root(w_root),
        .o_side(w_side)
    );

    assign w_tag_s = w_side[SIDE_W-1 -: $bits(t_tag)];

    atl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_x  (CW'(w_root)),
        .i_y  (w_side[CW-1:0]),
        .i_tag(w_tag_s),
        .o_z  (w_z),
        .o_tag(w_tag_c)
    );

    // rounding, ties away from zero, then saturation
    logic [ZW-1:0] w_mag, w_rnd, w_sat;
    logic [OW-1:0] w_res;

    always_comb begin
        w_mag = w_z[ZW-1] ? ZW'(-w_z) : ZW'(w_z);
        w_rnd = (w_mag + HALF_Z) >> DROP;
        w_sat = (w_rnd > FULL_Z) ? FULL_Z : w_rnd;
        if (w_tag_c.spec) begin
            if (w_tag_c.zero)     w_res = '0;
            else if (w_tag_c.neg) w_res = OW'(-FULL_Z);
            else                  w_res = OW'(FULL_Z);
        end else begin
            w_res = w_z[ZW-1] ? OW'(-w_sat) : OW'(w_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= w_res;
        end
    end
endmodule

/* sv/accel_tilt_angles_top.sv */
// channel   | dir | fields                        | width
// i_smp     | in  | accel_x, accel_y, accel_z     | SAMPLE_WIDTH, signed
// o_ang     | out | angle_x, angle_y, angle_z     | FRACTION_BITS+8, signed
//
// one request per cycle sustained while the output is not stalled; lane pipeline stages:
// squares, radicand, 31 square-root bit stages, one stage per cordic step, rounding
// i_rst_n is synchronous and clears only the valid bits
// a stall at the output freezes the whole pipeline; ready follows the last valid bit
// depends on atl_pkg, atl_ifs, atl_lane
module accel_tilt_angles_top import atl_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    atl_smp_if.snk i_smp,
    atl_ang_if.src o_ang
);
    // pipeline depth of a lane
    localparam int LAT = 3 + ROOT_W + CORDIC_STEPS;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // advance whenever the last stage is empty or being taken
    assign w_en        = !r_vld[LAT-1] || o_ang.ready;
    assign i_smp.ready = w_en;
    assign o_ang.valid = r_vld[LAT-1];

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_smp.valid};
        end
    end

    // x tilt: own x, others y and z
    atl_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_lane_x (
        .i_clk(i_clk), .i_en(w_en),
        .i_own(i_smp.accel_x), .i_oth_b(i_smp.accel_y), .i_oth_c(i_smp.accel_z),
        .o_angle(o_ang.angle_x)
    );

    // y tilt: own y, others x and z
    atl_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_lane_y (
        .i_clk(i_clk), .i_en(w_en),
        .i_own(i_smp.accel_y), .i_oth_b(i_smp.accel_x), .i_oth_c(i_smp.accel_z),
        .o_angle(o_ang.angle_y)
    );

    // z tilt: own z, others x and y
    atl_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_lane_z (
        .i_clk(i_clk), .i_en(w_en),
        .i_own(i_smp.accel_z), .i_oth_b(i_smp.accel_x), .i_oth_c(i_smp.accel_y),
        .o_angle(o_ang.angle_z)
    );
endmodule

/* sv/atl_checker.sv */
// atl_checker: port-level checks of the tilt angle block, bound to the top
// depends on accel_tilt_angles_top
module atl_checker #(
    parameter int FRACTION_BITS = 8
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic signed [FRACTION_BITS+7:0] i_angle_x,
    input logic signed [FRACTION_BITS+7:0] i_angle_y,
    input logic signed [FRACTION_BITS+7:0] i_angle_z
);
    localparam logic signed [FRACTION_BITS+8:0] FULL = (FRACTION_BITS+9)'(90) <<< FRACTION_BITS;

    // stalled request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_angle_x)
            && $stable(i_angle_y) && $stable(i_angle_z))
        else $error("angle request changed while stalled");

    // angles stay within +-90 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_angle_x) <= FULL) && ($signed(i_angle_x) >= -FULL)
            && ($signed(i_angle_y) <= FULL) && ($signed(i_angle_y) >= -FULL)
            && ($signed(i_angle_z) <= FULL) && ($signed(i_angle_z) >= -FULL))
        else $error("angle out of range");

    // an empty output stage never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a refused input request means a full, stalled output
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused without output stall");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind accel_tilt_angles_top atl_checker #(.FRACTION_BITS(FRACTION_BITS)) u_atl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_smp.valid),
    .i_in_ready (i_smp.ready),
    .i_out_valid(o_ang.valid),
    .i_out_ready(o_ang.ready),
    .i_angle_x  (o_ang.angle_x),
    .i_angle_y  (o_ang.angle_y),
    .i_angle_z  (o_ang.angle_z)
);
